// File: rtl/core/ipm_pkg.sv
// Package for the inverter protection mode supervisor.
// Mode, register index and result types for core files but ipm_if; no dependencies.
package ipm_pkg;

  localparam int unsigned CfgW = 16;
  localparam int unsigned CntW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] WaitDelayRst  = 16'd1000;
  localparam logic [CfgW-1:0] CheckDelayRst = 16'd20;
  localparam logic [CfgW-1:0] RecoverDlyRst = 16'd500;
  localparam logic [CfgW-1:0] AutoClrPerRst = 16'd2000;

  typedef enum logic [2:0] {
    MODE_WAIT  = 3'd0,
    MODE_CHECK = 3'd1,
    MODE_RUN   = 3'd2,
    MODE_FAULT = 3'd3,
    MODE_PERM  = 3'd4
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WAIT_DELAY    = 2'd0,
    REG_CHECK_DELAY   = 2'd1,
    REG_RECOVER_DELAY = 2'd2,
    REG_AUTO_CLR_PER  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DRY_NONE  = 2'd0,
    DRY_OPEN  = 2'd1,
    DRY_CLOSE = 2'd2
  } dry_cmd_t;

  typedef enum logic [1:0] {
    SYNC_NONE    = 2'd0,
    SYNC_ASSERT  = 2'd1,
    SYNC_RELEASE = 2'd2
  } sync_cmd_t;

  typedef struct packed {
    logic [CfgW-1:0] wait_delay;
    logic [CfgW-1:0] check_delay;
    logic [CfgW-1:0] recover_delay;
    logic [CfgW-1:0] auto_clear_period;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic       pwm_off;
    logic       relays_off;
    logic [1:0] dry_contact_cmd;
    logic       fan_on;
    logic       precharge_request;
    logic       stage_init;
    logic       save_request;
    logic [1:0] sync_cmd;
    logic       clear_auto_faults;
    logic       recovered;
  } result_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// File: rtl/core/ipm_if.sv
// Valid/ready channel interfaces for the protection supervisor.
// Depends on nothing; one interface per direction.
interface ipm_in_if;
  logic valid;
  logic ready;
  logic permanent_fault;
  logic fault_active;
  logic phase_locked;
  logic precharge_done;

  modport source (output valid, permanent_fault, fault_active, phase_locked,
                  precharge_done, input ready);
  modport sink (input valid, permanent_fault, fault_active, phase_locked,
                precharge_done, output ready);
endinterface

interface ipm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode_now;
  logic       pwm_off;
  logic       relays_off;
  logic [1:0] dry_contact_cmd;
  logic       fan_on;
  logic       precharge_request;
  logic       stage_init;
  logic       save_request;
  logic [1:0] sync_cmd;
  logic       clear_auto_faults;
  logic       recovered;

  modport source (output valid, mode_now, pwm_off, relays_off, dry_contact_cmd, fan_on,
                  precharge_request, stage_init, save_request, sync_cmd,
                  clear_auto_faults, recovered, input ready);
  modport sink (input valid, mode_now, pwm_off, relays_off, dry_contact_cmd, fan_on,
                precharge_request, stage_init, save_request, sync_cmd,
                clear_auto_faults, recovered, output ready);
endinterface

// File: rtl/core/inverter_protection_mode_fsm_core.sv
// Protection mode supervisor for a power converter: one request per control tick
// on in_chan (fault flags, phase lock, precharge done), one result per request on
// out_chan (mode after the tick plus pwm, relay, contact, fan, precharge, init,
// save, sync, auto-clear and recovery commands).
// Registers are written through cfg_we/cfg_index/cfg_wdata: 0 wait delay, 1 check
// delay, 2 recover delay, 3 auto-clear period. The user must write them only
// while the block is idle; the block does not enforce it. Results are registered
// on acceptance, on out_chan from the next cycle; one request per cycle while
// out_chan does not stall, set by the single mode and counter update between the
// request and the result register. Stall: in_chan.ready stays high while the
// result register is empty or being taken; when out_chan.ready is low with a
// result held, in_chan.ready drops and the held result stays put until taken.
// Reset (rst_n low, synchronous): wait mode, all counters and save flags zero,
// registers back to 1000 / 20 / 500 / 2000, no result pending.
// Files: ipm_pkg, ipm_if, ipm_cfg, ipm_ctrl, ipm_out_stage.
module inverter_protection_mode_fsm_core (
  input  logic                        clk,
  input  logic                        rst_n,
  ipm_in_if.sink                      in_chan,
  ipm_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [ipm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ipm_pkg::CfgW-1:0]    cfg_wdata
);

  ipm_pkg::cfg_t    cfg;
  ipm_pkg::result_t res;
  ipm_pkg::result_t out_res;
  logic             can_load;
  logic             accept;

  assign in_chan.ready = can_load;
  assign accept        = in_chan.valid && can_load;

  ipm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ipm_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (accept),
    .permanent_fault (in_chan.permanent_fault),
    .fault_active    (in_chan.fault_active),
    .phase_locked    (in_chan.phase_locked),
    .precharge_done  (in_chan.precharge_done),
    .cfg             (cfg),
    .res             (res)
  );

  ipm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .res       (res),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .can_load  (can_load),
    .out_res   (out_res)
  );

  assign out_chan.mode_now          = out_res.mode_now;
  assign out_chan.pwm_off           = out_res.pwm_off;
  assign out_chan.relays_off        = out_res.relays_off;
  assign out_chan.dry_contact_cmd   = out_res.dry_contact_cmd;
  assign out_chan.fan_on            = out_res.fan_on;
  assign out_chan.precharge_request = out_res.precharge_request;
  assign out_chan.stage_init        = out_res.stage_init;
  assign out_chan.save_request      = out_res.save_request;
  assign out_chan.sync_cmd          = out_res.sync_cmd;
  assign out_chan.clear_auto_faults = out_res.clear_auto_faults;
  assign out_chan.recovered         = out_res.recovered;

endmodule

// File: rtl/core/ipm_cfg.sv
// Configuration register file for the protection supervisor.
// Uses ipm_pkg for the register index codes and reset values.
module ipm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [ipm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ipm_pkg::CfgW-1:0]    cfg_wdata,
  output ipm_pkg::cfg_t               cfg
);

  ipm_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (ipm_pkg::cfg_idx_t'(cfg_index))
        ipm_pkg::REG_WAIT_DELAY:    cfg_nxt.wait_delay        = cfg_wdata;
        ipm_pkg::REG_CHECK_DELAY:   cfg_nxt.check_delay       = cfg_wdata;
        ipm_pkg::REG_RECOVER_DELAY: cfg_nxt.recover_delay     = cfg_wdata;
        ipm_pkg::REG_AUTO_CLR_PER:  cfg_nxt.auto_clear_period = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wait_delay        <= ipm_pkg::WaitDelayRst;
      cfg_r.check_delay       <= ipm_pkg::CheckDelayRst;
      cfg_r.recover_delay     <= ipm_pkg::RecoverDlyRst;
      cfg_r.auto_clear_period <= ipm_pkg::AutoClrPerRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/ipm_ctrl.sv
// Mode state machine and tick counters of the protection supervisor.
// Uses ipm_pkg for the mode enum, config and result structs.
module ipm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             permanent_fault,
  input  logic             fault_active,
  input  logic             phase_locked,
  input  logic             precharge_done,
  input  ipm_pkg::cfg_t    cfg,
  output ipm_pkg::result_t res
);

  ipm_pkg::mode_t mode_r, mode_nxt;
  logic [ipm_pkg::CntW-1:0] wait_cnt_r, wait_cnt_nxt;
  logic [ipm_pkg::CntW-1:0] check_cnt_r, check_cnt_nxt;
  logic [ipm_pkg::CntW-1:0] ftick_cnt_r, ftick_cnt_nxt;
  logic [ipm_pkg::CntW-1:0] rec_cnt_r, rec_cnt_nxt;
  logic fault_saved_r, fault_saved_nxt;
  logic perm_saved_r, perm_saved_nxt;

  logic [ipm_pkg::CntW-1:0] wait_inc, check_inc, ftick_inc, rec_inc;

  assign wait_inc  = ipm_pkg::sat_inc(wait_cnt_r);
  assign check_inc = ipm_pkg::sat_inc(check_cnt_r);
  assign ftick_inc = ipm_pkg::sat_inc(ftick_cnt_r);
  assign rec_inc   = ipm_pkg::sat_inc(rec_cnt_r);

  always_comb begin
    mode_nxt        = mode_r;
    wait_cnt_nxt    = wait_cnt_r;
    check_cnt_nxt   = check_cnt_r;
    ftick_cnt_nxt   = ftick_cnt_r;
    rec_cnt_nxt     = rec_cnt_r;
    fault_saved_nxt = fault_saved_r;
    perm_saved_nxt  = perm_saved_r;
    res             = '0;

    unique case (mode_r)
      ipm_pkg::MODE_WAIT, ipm_pkg::MODE_CHECK, ipm_pkg::MODE_RUN: begin
        if (permanent_fault || fault_active) begin
          res.pwm_off         = 1'b1;
          res.relays_off      = 1'b1;
          res.dry_contact_cmd = ipm_pkg::DRY_OPEN;
          if (mode_r == ipm_pkg::MODE_WAIT) wait_cnt_nxt = '0;
          mode_nxt = permanent_fault ? ipm_pkg::MODE_PERM : ipm_pkg::MODE_FAULT;
        end else if (mode_r == ipm_pkg::MODE_WAIT) begin
          // count includes this tick before the compare
          if ((wait_inc > cfg.wait_delay) && phase_locked) begin
            wait_cnt_nxt = '0;
            mode_nxt     = ipm_pkg::MODE_CHECK;
          end else begin
            wait_cnt_nxt = wait_inc;
          end
        end else if (mode_r == ipm_pkg::MODE_CHECK) begin
          res.fan_on            = 1'b1;
          res.precharge_request = 1'b1;
          if (precharge_done) begin
            if (check_cnt_r > cfg.check_delay) begin
              check_cnt_nxt  = '0;
              res.stage_init = 1'b1;
              mode_nxt       = ipm_pkg::MODE_RUN;
            end else begin
              check_cnt_nxt = check_inc;
            end
          end
        end
      end
      ipm_pkg::MODE_FAULT: begin
        res.pwm_off    = 1'b1;
        res.relays_off = 1'b1;
        if (permanent_fault) begin
          mode_nxt = ipm_pkg::MODE_PERM;
        end else begin
          if (ftick_inc >= cfg.auto_clear_period) begin
            res.clear_auto_faults = 1'b1;
            ftick_cnt_nxt         = '0;
          end else begin
            ftick_cnt_nxt = ftick_inc;
          end
          if (!fault_saved_r) begin
            res.save_request = 1'b1;
            res.sync_cmd     = ipm_pkg::SYNC_ASSERT;
            fault_saved_nxt  = 1'b1;
          end
          if (!fault_active) begin
            if (rec_inc >= cfg.recover_delay) begin
              // recovery on the save tick still reports release
              res.recovered       = 1'b1;
              res.sync_cmd        = ipm_pkg::SYNC_RELEASE;
              res.dry_contact_cmd = ipm_pkg::DRY_CLOSE;
              rec_cnt_nxt         = '0;
              fault_saved_nxt     = 1'b0;
              mode_nxt            = ipm_pkg::MODE_WAIT;
            end else begin
              rec_cnt_nxt = rec_inc;
            end
          end
        end
      end
      ipm_pkg::MODE_PERM: begin
        res.sync_cmd   = ipm_pkg::SYNC_ASSERT;
        res.pwm_off    = 1'b1;
        res.relays_off = 1'b1;
        if (!perm_saved_r) begin
          res.save_request = 1'b1;
          perm_saved_nxt   = 1'b1;
        end
      end
      default: begin
        res = '0;
      end
    endcase

    res.mode_now = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= ipm_pkg::MODE_WAIT;
      wait_cnt_r    <= '0;
      check_cnt_r   <= '0;
      ftick_cnt_r   <= '0;
      rec_cnt_r     <= '0;
      fault_saved_r <= 1'b0;
      perm_saved_r  <= 1'b0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      wait_cnt_r    <= wait_cnt_nxt;
      check_cnt_r   <= check_cnt_nxt;
      ftick_cnt_r   <= ftick_cnt_nxt;
      rec_cnt_r     <= rec_cnt_nxt;
      fault_saved_r <= fault_saved_nxt;
      perm_saved_r  <= perm_saved_nxt;
    end
  end

endmodule

// File: rtl/core/ipm_out_stage.sv
// Result register with valid/ready handshake; takes a new result whenever it
// is empty or being drained. Uses ipm_pkg::result_t.
module ipm_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ipm_pkg::result_t res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             can_load,
  output ipm_pkg::result_t out_res
);

  logic             valid_r, valid_nxt;
  ipm_pkg::result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
